[rtl/lru_replacement_tracker_assert.svh]
// Assertion macros shared by the LRU tracker RTL.
`ifndef LRU_REPLACEMENT_TRACKER_ASSERT_SVH
`define LRU_REPLACEMENT_TRACKER_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define LRUT_CHECK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lru tracker check failed");

// Check that an antecedent implies a consequent in the following cycle.
`define LRUT_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru tracker sequence check failed");

`endif

[rtl/lrut_pkg.sv]
// Shared types and constants for the LRU replacement tracker.
`default_nettype none

package lrut_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int ACTION_BITS  = 2;
    localparam int STATUS_BITS  = 2;

    localparam logic [ACTION_BITS-1:0] ACT_TOUCH  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_VICTIM = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_ERASE  = 2'd2;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

endpackage

`default_nettype wire

[rtl/lrut_in_stage.sv]
// Input register stage holding one item for the slot array.
`default_nettype none

module lrut_in_stage #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [WIDTH-1:0] s_data,
    input  wire logic             take,
    output logic                  valid,
    output logic      [WIDTH-1:0] data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign s_ready = !valid_reg || take;
    assign valid   = valid_reg;
    assign data    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_valid && s_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            data_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

[rtl/lrut_slot_array.sv]
// Slot array: keys, valid bits, age ranks, count, and their update on each accepted item.
`default_nettype none
`include "lru_replacement_tracker_assert.svh"

module lrut_slot_array #(
    parameter  int ENTRIES   = lrut_pkg::ENTRIES_DEF,
    parameter  int KEY_BITS  = lrut_pkg::KEY_BITS_DEF,
    localparam int RANK_BITS = $clog2(ENTRIES),
    localparam int CNT_BITS  = $clog2(ENTRIES + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              fire,
    input  wire logic [lrut_pkg::ACTION_BITS-1:0]  action,
    input  wire logic [KEY_BITS-1:0]               key,
    output lrut_pkg::status_t                      status,
    output logic      [KEY_BITS-1:0]               victim_key,
    output logic      [CNT_BITS-1:0]               entry_count
);

    logic [KEY_BITS-1:0]  key_reg  [ENTRIES];
    logic [RANK_BITS-1:0] rank_reg [ENTRIES];
    logic [RANK_BITS-1:0] rank_next[ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;

    logic [ENTRIES-1:0]   match;
    logic [ENTRIES-1:0]   oldest;
    logic [ENTRIES-1:0]   oldest_sel;
    logic [ENTRIES-1:0]   free_sel;
    logic [ENTRIES-1:0]   drop_sel;
    logic [ENTRIES-1:0]   write_sel;
    logic [RANK_BITS-1:0] drop_rank;
    logic [RANK_BITS-1:0] new_rank;
    logic [KEY_BITS-1:0]  oldest_key;
    logic                 hit;
    logic                 has_old;
    logic                 has_free;
    logic                 full_fire;
    logic                 victim_fire;

    // Match every slot in parallel.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]  = valid_reg[i] && (key_reg[i] == key);
            oldest[i] = valid_reg[i] && (rank_reg[i] == '0);
        end
    end

    // Isolate the lowest set oldest bit and the lowest clear valid bit.
    assign oldest_sel = oldest & (~oldest + 1'b1);
    assign free_sel   = ~valid_reg & (valid_reg + 1'b1);
    assign hit        = |match;
    assign has_old    = |oldest;
    assign has_free   = ~&valid_reg;

    always_comb
    begin
        oldest_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            oldest_key = oldest_key | (key_reg[i] & {KEY_BITS{oldest_sel[i]}});
        end
    end

    always_comb
    begin
        status     = lrut_pkg::ST_DONE;
        drop_sel   = '0;
        write_sel  = '0;
        new_rank   = '0;
        count_next = count_reg;
        victim_key = '0;
        unique case (action)
            lrut_pkg::ACT_TOUCH:
            begin
                if (hit)
                begin
                    drop_sel  = match;
                    write_sel = match;
                    new_rank  = RANK_BITS'(count_reg - 1'b1);
                end
                else if (!has_free)
                begin
                    status = lrut_pkg::ST_FULL;
                end
                else
                begin
                    write_sel  = free_sel;
                    new_rank   = RANK_BITS'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            lrut_pkg::ACT_VICTIM:
            begin
                if (has_old)
                begin
                    drop_sel   = oldest_sel;
                    victim_key = oldest_key;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status = lrut_pkg::ST_MISS;
                end
            end
            lrut_pkg::ACT_ERASE:
            begin
                if (hit)
                begin
                    drop_sel   = match;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status = lrut_pkg::ST_MISS;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign entry_count = count_next;

    always_comb
    begin
        drop_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            drop_rank = drop_rank | (rank_reg[i] & {RANK_BITS{drop_sel[i]}});
        end
    end

    // Age younger slots, free the dropped slot, place the written one as newest.
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (valid_reg[i] && !drop_sel[i] && (|drop_sel) && (rank_reg[i] > drop_rank))
            begin
                rank_next[i] = rank_reg[i] - 1'b1;
            end
            if (drop_sel[i])
            begin
                valid_next[i] = 1'b0;
                rank_next[i]  = '0;
            end
            if (write_sel[i])
            begin
                valid_next[i] = 1'b1;
                rank_next[i]  = new_rank;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (fire && write_sel[i])
            begin
                key_reg[i] <= key;
            end
        end
    end

    assign full_fire   = fire && (status == lrut_pkg::ST_FULL);
    assign victim_fire = fire && (action == lrut_pkg::ACT_VICTIM) && (status == lrut_pkg::ST_DONE);

    `LRUT_CHECK(a_count_matches_valid, $countones(valid_reg) == int'(count_reg))
    `LRUT_CHECK_NEXT(a_full_keeps_count, full_fire, $stable(count_reg))
    `LRUT_CHECK_NEXT(a_victim_shrinks, victim_fire, count_reg == CNT_BITS'($past(count_reg) - 1'b1))

endmodule

`default_nettype wire

[rtl/lrut_out_stage.sv]
// Result register holding one item until the downstream side takes it.
`default_nettype none

module lrut_out_stage #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic [WIDTH-1:0] data_in,
    output logic                  room,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [WIDTH-1:0] m_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign room    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_in;
        end
    end

endmodule

`default_nettype wire

[rtl/lru_replacement_tracker.sv]
// Top level of the LRU replacement tracker.
//
//  channel  | direction | tdata fields (low bit first)          | tuser / tlast
//  s_axis   | in        | action[1:0], key[KEY_BITS-1:0]        | none
//  m_axis   | out       | status[1:0], victim_key, entry_count  | none
//
// One item per cycle while the result register has room: the item waits in the
// input register and the slot array match, rank update and count finish in that
// cycle into the result register; the result passes both registers in turn.
// Reset clears valid bits, ranks and count at once; no clearing pass.
// A stalled result holds the next item in the input register; the state moves
// only when an item passes into the result register.
`default_nettype none

module lru_replacement_tracker #(
    parameter  int ENTRIES     = lrut_pkg::ENTRIES_DEF,
    parameter  int KEY_BITS    = lrut_pkg::KEY_BITS_DEF,
    localparam int CNT_BITS    = $clog2(ENTRIES + 1),
    localparam int IN_W        = lrut_pkg::ACTION_BITS + KEY_BITS,
    localparam int OUT_W       = lrut_pkg::STATUS_BITS + KEY_BITS + CNT_BITS,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // action, key, zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status, victim_key, entry_count, zero fill
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                               in_valid;
    logic [IN_W-1:0]                    in_data;
    logic                               out_room;
    logic                               fire;
    lrut_pkg::status_t                  status;
    logic [KEY_BITS-1:0]                victim_key;
    logic [CNT_BITS-1:0]                entry_count;
    logic [OUT_W-1:0]                   result;
    logic [OUT_W-1:0]                   out_data;

    assign fire = in_valid && out_room;

    lrut_in_stage #(
        .WIDTH (IN_W)
    ) u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata[IN_W-1:0]),
        .take    (fire),
        .valid   (in_valid),
        .data    (in_data)
    );

    lrut_slot_array #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_slot_array (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .action      (in_data[lrut_pkg::ACTION_BITS-1:0]),
        .key         (in_data[IN_W-1:lrut_pkg::ACTION_BITS]),
        .status      (status),
        .victim_key  (victim_key),
        .entry_count (entry_count)
    );

    assign result = {entry_count, victim_key, status};

    lrut_out_stage #(
        .WIDTH (OUT_W)
    ) u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (fire),
        .data_in (result),
        .room    (out_room),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (out_data)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_data);

endmodule

`default_nettype wire
